FILE: design/base64_stream_decoder_core_assert.svh
// Assertion macros shared by the base64 decoder RTL.
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define B64D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define B64D_ASSERT_IMP(lbl, ante, cons) \
  `B64D_ASSERT(lbl, (ante) |-> (cons))

`endif

FILE: design/b64d_pkg.sv
// Types, constants and alphabet lookup for the base64 decoder.
package b64d_pkg;

  localparam int unsigned MaxCharsDefault = 256;
  // Depth of the result group buffer, in groups.
  localparam int unsigned FifoDepth = 4;

  localparam logic [5:0] AlphaLowerBase = 6'd26;
  localparam logic [5:0] AlphaDigitBase = 6'd52;
  localparam logic [5:0] CodePlus = 6'd62;
  localparam logic [5:0] CodeSlash = 6'd63;

  // Up to three results caused by one input transaction.
  typedef struct packed {
    logic [1:0]      num;       // 1 to 3 results
    logic            has_byte;  // 0 only for a bare end marker
    logic            last;      // final result carries last_of_string
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t group;
  } push_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t alpha_lookup(input logic [6:0] c);
    sextet_t r;
    r = '0;
    case (c) inside
      [7'h41:7'h5A]: begin
        r.hit   = 1'b1;
        r.value = 6'(c - 7'h41);
      end
      [7'h61:7'h7A]: begin
        r.hit   = 1'b1;
        r.value = 6'(c - 7'h61) + AlphaLowerBase;
      end
      [7'h30:7'h39]: begin
        r.hit   = 1'b1;
        r.value = 6'(c - 7'h30) + AlphaDigitBase;
      end
      7'h2B: begin
        r.hit   = 1'b1;
        r.value = CodePlus;
      end
      7'h2F: begin
        r.hit   = 1'b1;
        r.value = CodeSlash;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

endpackage

FILE: design/b64d_if.sv
// Valid/ready stream interfaces for decoder input and output.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_of_string;

  modport source (output valid, output data_byte, output has_byte, output last_of_string,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last_of_string,
                output ready);
endinterface

FILE: design/b64d_decode.sv
// Decode state and per-character group assembly.
`include "base64_stream_decoder_core_assert.svh"

module b64d_decode #(
  parameter int unsigned MaxChars = b64d_pkg::MaxCharsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_string_i,
  output b64d_pkg::push_t  push_o
);

  localparam int unsigned CntW = $clog2(MaxChars + 1);

  logic [1:0]      phase_q, phase_d;
  logic [17:0]     held_q, held_d;
  logic            skip_q, skip_d;
  logic            stopped_q, stopped_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  b64d_pkg::sextet_t lk;
  logic [5:0]        s0, s1, s2;

  assign s0 = held_q[17:12];
  assign s1 = held_q[11:6];
  assign s2 = held_q[5:0];
  assign lk = b64d_pkg::alpha_lookup(char_code_i[6:0]);

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    skip_d    = skip_q;
    stopped_d = stopped_q;
    cnt_d     = cnt_q;
    push_o    = '0;
    if (accept_i) begin
      if (end_of_string_i) begin
        push_o.valid          = 1'b1;
        push_o.group.last     = 1'b1;
        push_o.group.has_byte = 1'b1;
        case (phase_q)
          2'd3: begin
            push_o.group.num      = 2'd3;
            push_o.group.bytes[0] = {s0, s1[5:4]};
            push_o.group.bytes[1] = {s1[3:0], s2[5:2]};
            push_o.group.bytes[2] = {s2[1:0], 6'b0};
          end
          2'd2: begin
            push_o.group.num      = 2'd2;
            push_o.group.bytes[0] = {s0, s1[5:4]};
            push_o.group.bytes[1] = {s1[3:0], 4'b0};
          end
          2'd1: begin
            push_o.group.num      = 2'd1;
            push_o.group.bytes[0] = {s0, 2'b0};
          end
          default: begin
            push_o.group.num      = 2'd1;
            push_o.group.has_byte = 1'b0;
          end
        endcase
        phase_d   = '0;
        held_d    = '0;
        skip_d    = 1'b1;
        stopped_d = 1'b0;
        cnt_d     = '0;
      end else if (!(skip_q && b64d_pkg::is_space(char_code_i))) begin
        skip_d = 1'b0;
        if (!stopped_q && (cnt_q < CntW'(MaxChars))) begin
          cnt_d = cnt_q + CntW'(1);
          if (!lk.hit) begin
            stopped_d = 1'b1;
          end else if (phase_q == 2'd3) begin
            push_o.valid          = 1'b1;
            push_o.group.has_byte = 1'b1;
            push_o.group.num      = 2'd3;
            push_o.group.bytes[0] = {s0, s1[5:4]};
            push_o.group.bytes[1] = {s1[3:0], s2[5:2]};
            push_o.group.bytes[2] = {s2[1:0], lk.value};
            phase_d = '0;
            held_d  = '0;
          end else begin
            held_d  = {held_q[11:0], lk.value};
            phase_d = phase_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      held_q    <= '0;
      skip_q    <= 1'b1;
      stopped_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      skip_q    <= skip_d;
      stopped_q <= stopped_d;
      cnt_q     <= cnt_d;
    end
  end

  `B64D_ASSERT(cnt_in_range_a, cnt_q <= CntW'(MaxChars))
  `B64D_ASSERT_IMP(skip_clean_a, skip_q, (cnt_q == '0) && (phase_q == 2'd0) && !stopped_q)
  `B64D_ASSERT_IMP(stopped_after_skip_a, stopped_q, !skip_q && (cnt_q != '0))

endmodule

FILE: design/b64d_out_buf.sv
// Result group buffer and byte-by-byte output serializer.
`include "base64_stream_decoder_core_assert.svh"

module b64d_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64d_pkg::push_t      push_i,
  output logic                 ready_o,
  b64d_out_if.source           out_o
);

  localparam int unsigned PtrW = (b64d_pkg::FifoDepth > 1) ? $clog2(b64d_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(b64d_pkg::FifoDepth + 1);

  b64d_pkg::group_t mem_q [b64d_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       idx_q, idx_d;

  b64d_pkg::group_t head;
  logic             out_xfer, pop, at_end;

  assign head     = mem_q[rd_q];
  assign ready_o  = (cnt_q != CntW'(b64d_pkg::FifoDepth));
  assign out_xfer = out_o.valid && out_o.ready;
  assign at_end   = (idx_q == (head.num - 2'd1));
  assign pop      = out_xfer && at_end;

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.data_byte      = head.bytes[idx_q];
  assign out_o.has_byte       = head.has_byte;
  assign out_o.last_of_string = head.last && at_end;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = (wr_q == PtrW'(b64d_pkg::FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (out_xfer) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(b64d_pkg::FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i.valid) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.group;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  `B64D_ASSERT(cnt_bound_a, cnt_q <= CntW'(b64d_pkg::FifoDepth))
  `B64D_ASSERT_IMP(no_overflow_a, push_i.valid, ready_o)
  `B64D_ASSERT_IMP(idx_in_group_a, out_o.valid, (idx_q < head.num) && (head.num != 2'd0))

endmodule

FILE: design/base64_stream_decoder_core.sv
// Streaming base64 decoder: one character transaction in, decoded byte transactions out.
// Accepts one character (or end marker) per clock while in_i.ready is high. Leading whitespace
// is skipped, at most MaxChars characters are decoded, and the first character outside the
// alphabet ends decoding until the end marker. Each character is decoded combinationally
// into a group of up to three bytes, registered into a four-group result buffer; bytes
// leave at one byte per cycle while out_o.ready is high. in_i.ready is low only while that
// buffer holds four groups, so with the output always ready the input runs at one character
// per cycle indefinitely. The end marker flushes the partial group (or a bare marker with
// has_byte low), flags its final result with last_of_string and restarts for the next string.
module base64_stream_decoder_core #(
  parameter int unsigned MaxChars = b64d_pkg::MaxCharsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o
);

  b64d_pkg::push_t push;
  logic            buf_ready;
  logic            accept;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  b64d_decode #(
    .MaxChars(MaxChars)
  ) u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_code_i    (in_i.char_code),
    .end_of_string_i(in_i.end_of_string),
    .push_o         (push)
  );

  b64d_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ready_o(buf_ready),
    .out_o  (out_o)
  );

endmodule
